@@ rtl/wrm_pkg.sv @@
// Shared types and constants for the windowed event rate meter.
`default_nettype none

package wrm_pkg;

    // Fixed-point constants used when the window weights are built at elaboration
    localparam longint Q30_ONE    = 64'sd1 << 30;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    localparam int COUNT_W = 16;
    localparam int RATE_W  = 16;
    localparam int TICK_W  = 32;

    typedef struct packed {
        logic accept;     // capture the request's tick
        logic update;     // advance or clear the ring for the captured tick
        logic rd_newest;  // read the newest bucket
        logic write_inc;  // write the incremented newest bucket back
        logic mac_start;  // clear accumulator, point at the oldest bucket
        logic mac_issue;  // read one bucket and its weight
        logic finish;     // round, saturate and load the result register
    } wrm_cmd_t;

    typedef struct packed {
        logic mac_last;   // current issue is the newest completed bucket
        logic mac_busy;   // products still in flight
        logic out_free;   // result register can take a value this cycle
    } wrm_status_t;

endpackage

`default_nettype wire

@@ rtl/windowed_event_rate_meter_top.sv @@
// Top level of the Blackman-windowed event rate meter.
`default_nettype none

// Each request is one event carrying its bucket tick; each yields one rate result.
// The time from one acceptance to the next is set by the single read port
// of the bucket count memory, which feeds one multiply-accumulate per
// completed bucket. The result sits in an output register, so a new request
// is taken while the previous result still waits; a request finishes only
// once that register is free.
// Ticks are taken as non-decreasing; an earlier tick counts in the newest bucket.

module windowed_event_rate_meter_top
    import wrm_pkg::*;
#(
    parameter int BUCKETS          = 32,
    parameter int INTERVAL_SECONDS = 1,
    parameter int WEIGHT_BITS      = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick_valid,
    output logic                   tick_stall,
    input  wire logic [TICK_W-1:0] tick,
    output logic                   rate_valid,
    input  wire logic              rate_stall,
    output logic      [RATE_W-1:0] rate
);

    wrm_cmd_t    cmd;
    wrm_status_t status;

    wrm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .cmd        (cmd),
        .status     (status)
    );

    wrm_datapath #(
        .BUCKETS          (BUCKETS),
        .INTERVAL_SECONDS (INTERVAL_SECONDS),
        .WEIGHT_BITS      (WEIGHT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cmd        (cmd),
        .status     (status),
        .rate       (rate),
        .rate_valid (rate_valid),
        .rate_stall (rate_stall)
    );

endmodule

`default_nettype wire

@@ rtl/wrm_weight_rom.sv @@
// Blackman window weight table, built at elaboration, registered read.
`default_nettype none

module wrm_weight_rom
    import wrm_pkg::*;
#(
    parameter int BUCKETS     = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic [$clog2(BUCKETS)-1:0] idx,
    output logic      [WEIGHT_BITS-1:0]     weight
);

    localparam longint RING_LEN  = longint'(BUCKETS) + 64'sd1;
    localparam longint RING_LEN2 = 2 * RING_LEN;

    // cos(2*pi*a/den) in Q30 for angles in the first quadrant;
    // den is the ring length, or twice it when wide_den is set
    function automatic longint cos_quarter(input longint a, input bit wide_den);
        longint x;
        longint x2;
        longint t;
        if (wide_den)
            x = (TWO_PI_Q30 * a) / RING_LEN2;
        else
            x = (TWO_PI_Q30 * a) / RING_LEN;
        x2 = (x * x) / Q30_ONE;
        t  = Q30_ONE;
        t  = Q30_ONE - (x2 * t) / (Q30_ONE * 132);
        t  = Q30_ONE - (x2 * t) / (Q30_ONE * 90);
        t  = Q30_ONE - (x2 * t) / (Q30_ONE * 56);
        t  = Q30_ONE - (x2 * t) / (Q30_ONE * 30);
        t  = Q30_ONE - (x2 * t) / (Q30_ONE * 12);
        t  = Q30_ONE - (x2 * t) / (Q30_ONE * 2);
        return t;
    endfunction

    function automatic longint cos_turn(input longint k_in);
        longint k;
        k = k_in;
        if (2 * k > RING_LEN)
            k = RING_LEN - k;
        if (4 * k > RING_LEN)
            return -cos_quarter(RING_LEN - 2 * k, 1'b1);
        return cos_quarter(k, 1'b0);
    endfunction

    function automatic longint raw_weight(input int i);
        longint c;
        longint c2;
        longint c4;
        longint v;
        c  = cos_turn(longint'(i) + 64'sd1);
        c2 = (c * c) / Q30_ONE;
        c4 = 2 * c2 - Q30_ONE;
        v  = (42 * Q30_ONE - 50 * c + 8 * c4) / 100;
        if (v < 0)
            v = 0;
        return v;
    endfunction

    function automatic longint weight_total();
        longint s;
        s = 0;
        for (int i = 0; i < BUCKETS; i++)
            s = s + raw_weight(i);
        return s;
    endfunction

    localparam longint W_TOTAL = weight_total();
    localparam longint W_MAX   = (64'sd1 <<< WEIGHT_BITS) - 64'sd1;

    function automatic longint norm_weight(input int i);
        longint q;
        q = ((raw_weight(i) <<< WEIGHT_BITS) + W_TOTAL / 2) / W_TOTAL;
        if (q > W_MAX)
            q = W_MAX;
        return q;
    endfunction

    logic [WEIGHT_BITS-1:0] weight_tab [BUCKETS];

    for (genvar g = 0; g < BUCKETS; g++)
    begin : g_tab
        localparam longint WQ = norm_weight(g);
        assign weight_tab[g] = WQ[WEIGHT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        weight <= weight_tab[idx];
    end

endmodule

`default_nettype wire

@@ rtl/wrm_datapath.sv @@
// Bucket ring, tick bookkeeping, multiply-accumulate and result register.
`default_nettype none

module wrm_datapath
    import wrm_pkg::*;
#(
    parameter int BUCKETS          = 32,
    parameter int INTERVAL_SECONDS = 1,
    parameter int WEIGHT_BITS      = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [TICK_W-1:0]  tick,
    input  wire wrm_cmd_t           cmd,
    output wrm_status_t             status,
    output logic      [RATE_W-1:0]  rate,
    output logic                    rate_valid,
    input  wire logic               rate_stall
);

    localparam int RING_LEN = BUCKETS + 1;
    localparam int SLOT_W   = $clog2(RING_LEN);
    localparam int OFF_W    = SLOT_W + 1;
    localparam int IDX_W    = $clog2(BUCKETS);
    localparam int PROD_W   = COUNT_W + WEIGHT_BITS;
    localparam int ACC_W    = PROD_W + IDX_W + 1;
    localparam int INC      = BUCKETS / INTERVAL_SECONDS;

    logic [TICK_W-1:0]   tick_reg;
    logic [TICK_W-1:0]   newest_tick_reg, newest_tick_next;
    logic                primed_reg, primed_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [RING_LEN-1:0] valid_reg, valid_next;

    logic [COUNT_W-1:0]  ring_mem [RING_LEN];
    logic [COUNT_W-1:0]  rd_data_reg;
    logic                rd_valid_reg;
    logic [SLOT_W-1:0]   raddr;
    logic [COUNT_W-1:0]  rd_count;
    logic [COUNT_W:0]    inc_sum;
    logic [COUNT_W-1:0]  inc_sat;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;
    logic                issue_d_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                prod_v_reg;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [WEIGHT_BITS-1:0] weight;

    logic [ACC_W-1:0]    rounded;
    logic [ACC_W-1:0]    shifted;
    logic [RATE_W-1:0]   rate_reg;
    logic                rate_valid_reg;

    logic [TICK_W-1:0]   delta;
    logic                ahead;
    logic                gap;
    logic [OFF_W-1:0]    step;
    logic [OFF_W-1:0]    slot_sum;
    logic [SLOT_W-1:0]   slot_after;
    logic [RING_LEN-1:0] retire_mask;

    wrm_weight_rom #(
        .BUCKETS     (BUCKETS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_rom (
        .clk    (clk),
        .idx    (idx_reg),
        .weight (weight)
    );

    // Tick movement and the span of buckets it retires
    assign ahead = tick_reg > newest_tick_reg;
    assign delta = tick_reg - newest_tick_reg;
    assign gap   = delta > TICK_W'(BUCKETS);
    assign step  = delta[OFF_W-1:0];

    assign slot_sum   = OFF_W'(slot_reg) + step;
    assign slot_after = (slot_sum >= OFF_W'(RING_LEN))
                        ? SLOT_W'(slot_sum - OFF_W'(RING_LEN))
                        : SLOT_W'(slot_sum);

    // Bucket j retires when it lies within step places after the newest
    always_comb
    begin
        logic [OFF_W-1:0] off;
        for (int j = 0; j < RING_LEN; j++)
        begin
            off = OFF_W'(j) + OFF_W'(RING_LEN) - OFF_W'(slot_reg) - OFF_W'(1);
            if (off >= OFF_W'(RING_LEN))
                off = off - OFF_W'(RING_LEN);
            retire_mask[j] = off < step;
        end
    end

    assign rd_count = rd_valid_reg ? rd_data_reg : '0;
    assign inc_sum  = {1'b0, rd_count} + (COUNT_W+1)'(INC);
    assign inc_sat  = inc_sum[COUNT_W] ? '1 : inc_sum[COUNT_W-1:0];

    always_comb
    begin
        newest_tick_next = newest_tick_reg;
        primed_next      = primed_reg;
        slot_next        = slot_reg;
        valid_next       = valid_reg;
        if (cmd.update)
        begin
            priority if (!primed_reg)
            begin
                valid_next       = '0;
                slot_next        = '0;
                primed_next      = 1'b1;
                newest_tick_next = tick_reg;
            end
            else if (ahead)
            begin
                if (gap)
                begin
                    valid_next = '0;
                    slot_next  = '0;
                end
                else
                begin
                    valid_next = valid_reg & ~retire_mask;
                    slot_next  = slot_after;
                end
                newest_tick_next = tick_reg;
            end
            else
            begin
                newest_tick_next = newest_tick_reg;
            end
        end
        else if (cmd.write_inc)
        begin
            valid_next[slot_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_tick_reg <= '0;
            primed_reg      <= 1'b0;
            slot_reg        <= '0;
            valid_reg       <= '0;
        end
        else
        begin
            newest_tick_reg <= newest_tick_next;
            primed_reg      <= primed_next;
            slot_reg        <= slot_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            tick_reg <= tick;
    end

    // Count memory: one write port, one registered read port
    assign raddr = cmd.rd_newest ? slot_reg : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_inc)
            ring_mem[slot_reg] <= inc_sat;
        rd_data_reg  <= ring_mem[raddr];
        rd_valid_reg <= valid_reg[raddr];
    end

    // Oldest completed bucket sits one place after the newest
    always_comb
    begin
        idx_next = idx_reg;
        ptr_next = ptr_reg;
        if (cmd.mac_start)
        begin
            idx_next = '0;
            ptr_next = (slot_reg == SLOT_W'(RING_LEN - 1)) ? '0 : slot_reg + SLOT_W'(1);
        end
        else if (cmd.mac_issue)
        begin
            idx_next = idx_reg + IDX_W'(1);
            ptr_next = (ptr_reg == SLOT_W'(RING_LEN - 1)) ? '0 : ptr_reg + SLOT_W'(1);
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.mac_start)
            acc_next = '0;
        else if (prod_v_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_d_reg <= 1'b0;
            prod_v_reg  <= 1'b0;
        end
        else
        begin
            issue_d_reg <= cmd.mac_issue;
            prod_v_reg  <= issue_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        ptr_reg  <= ptr_next;
        prod_reg <= PROD_W'(rd_count) * PROD_W'(weight);
        acc_reg  <= acc_next;
    end

    assign rounded = acc_reg + (ACC_W'(1) << (WEIGHT_BITS - 1));
    assign shifted = rounded >> WEIGHT_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            rate_reg <= (|shifted[ACC_W-WEIGHT_BITS-1:RATE_W]) ? '1 : shifted[RATE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_valid_reg <= 1'b0;
        else if (cmd.finish)
            rate_valid_reg <= 1'b1;
        else if (!rate_stall)
            rate_valid_reg <= 1'b0;
    end

    assign rate       = rate_reg;
    assign rate_valid = rate_valid_reg;

    assign status.mac_last = idx_reg == IDX_W'(BUCKETS - 1);
    assign status.mac_busy = issue_d_reg | prod_v_reg;
    assign status.out_free = !rate_valid_reg || !rate_stall;

endmodule

`default_nettype wire

@@ rtl/wrm_ctrl.sv @@
// Sequencer for one request: ring update, bucket increment, weighted sum.
`default_nettype none

module wrm_ctrl
    import wrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        tick_valid,
    output logic             tick_stall,
    output wrm_cmd_t         cmd,
    input  wire wrm_status_t status
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_UPD   = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_INC   = 7'b0001000,
        ST_MAC   = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_FIN   = 7'b1000000
    } wrm_state_t;

    wrm_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = tick_valid;
                if (tick_valid)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd_newest = 1'b1;
                state_next    = ST_INC;
            end
            ST_INC:
            begin
                cmd.write_inc = 1'b1;
                cmd.mac_start = 1'b1;
                state_next    = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (status.mac_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!status.mac_busy)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold the sum until the result register frees up
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign tick_stall = state_reg != ST_IDLE;

endmodule

`default_nettype wire
